FILE: hdl/cordic_sine_cosine_unit_macros.svh
// Assertion macros of the CORDIC sine and cosine unit, used by its queue.
`ifndef CORDIC_SINE_COSINE_UNIT_MACROS_SVH
`define CORDIC_SINE_COSINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/csc_pkg.sv
// Package with the constants, types and tables of the CORDIC sine and cosine unit.
`timescale 1ns / 1ps
package csc_pkg;
    localparam int FRAC_BITS      = 16;
    localparam int ANGLE_W        = 32;
    localparam int OUT_W          = 18;
    localparam int T_W            = 20;
    localparam int DEF_ITERATIONS = 20;
    localparam int DEF_WORD_WIDTH = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [18:0] PI_FX      = 19'd205887;
    localparam logic [18:0] TWO_PI_FX  = 19'd411775;
    localparam logic [18:0] HALF_PI_FX = PI_FX >> 1;
    localparam logic signed [16:0] GAIN_FX = 17'sd39797;

    localparam int RECIP_SHIFT = 50;
    localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI_FX));

    typedef struct packed {
        logic signed [T_W-1:0] angle;
        logic                  negate;
    } t_task;

    function automatic logic [16:0] atan_fx(input int k);
        logic [16:0] v;
        v = 17'd0;
        case (k)
            0:  v = 17'd51472;
            1:  v = 17'd30386;
            2:  v = 17'd16055;
            3:  v = 17'd8150;
            4:  v = 17'd4091;
            5:  v = 17'd2047;
            6:  v = 17'd1024;
            7:  v = 17'd512;
            8:  v = 17'd256;
            9:  v = 17'd128;
            10: v = 17'd64;
            11: v = 17'd32;
            12: v = 17'd16;
            13: v = 17'd8;
            14: v = 17'd4;
            15: v = 17'd2;
            16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction
endpackage

FILE: hdl/csc_front.sv
// Front end: reduces the angle modulo two pi and folds it into the right half plane.
`timescale 1ns / 1ps
module csc_front import csc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_task                     o_task
);
    logic              r_v1, r_v2, r_v3, r_v4;
    logic [32:0]       r_x1, r_x2;
    logic              r_nb1, r_nb2, r_nb3;
    logic [14:0]       r_q;
    logic [19:0]       r_r0;
    t_task             r_task;

    logic                 w_en;
    logic signed [32:0]   w_a;
    logic                 w_nb;
    logic [32:0]          w_x;
    logic [64:0]          w_prod;
    logic [33:0]          w_qd;
    logic [19:0]          w_r;
    logic signed [T_W-1:0] w_t;
    t_task                n_task;

    assign w_en    = !r_v4 || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v4;
    assign o_task  = r_task;

    always_comb begin
        w_a    = 33'(i_angle);
        w_nb   = w_a < -$signed({14'd0, PI_FX});
        w_x    = w_nb ? 33'(-$signed({14'd0, PI_FX}) - w_a)
                      : 33'(w_a + $signed({14'd0, PI_FX}));
        w_prod = 65'(r_x1) * 65'(RECIP);
        w_qd   = 34'(r_q) * 34'(TWO_PI_FX);
        w_r    = (r_r0 >= 20'(TWO_PI_FX)) ? r_r0 - 20'(TWO_PI_FX) : r_r0;
        w_t    = r_nb3 ? $signed(20'(PI_FX) + 20'd1 - w_r) : $signed(w_r - 20'(PI_FX));
        n_task.angle  = w_t;
        n_task.negate = 1'b0;
        if (w_t < -$signed(20'(HALF_PI_FX))) begin
            n_task.angle  = w_t + $signed(20'(PI_FX));
            n_task.negate = 1'b1;
        end else if ($signed(20'(HALF_PI_FX)) < w_t) begin
            n_task.angle  = w_t - $signed(20'(PI_FX));
            n_task.negate = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1   <= w_x;
            r_nb1  <= w_nb;
            r_q    <= w_prod[RECIP_SHIFT +: 15];
            r_x2   <= r_x1;
            r_nb2  <= r_nb1;
            r_r0   <= 20'(r_x2 - w_qd[32:0]);
            r_nb3  <= r_nb2;
            r_task <= n_task;
        end
    end
endmodule

FILE: hdl/csc_queue.sv
// Short queue that decouples the front end from the rotation pipeline.
`timescale 1ns / 1ps
`include "cordic_sine_cosine_unit_macros.svh"
module csc_queue import csc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_task i_task,
    output logic  o_valid,
    input  logic  i_ready,
    output t_task o_task
);
    t_task             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_task  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CSC_ASSERT_IMP(a_count_bound, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH), "Queue count overflow.")
    `CSC_ASSERT_NXT(a_push_grows, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "Push lost.")
    `CSC_ASSERT_IMP(a_head_folded, o_valid, (o_task.angle >= -$signed(20'(HALF_PI_FX))) && (o_task.angle <= $signed(20'(HALF_PI_FX)) + 20'sd1), "Angle not folded.")
endmodule

FILE: hdl/csc_back.sv
// Back end: unrolled CORDIC rotation stages, gain multiply and sign correction.
`timescale 1ns / 1ps
module csc_back import csc_pkg::*; #(
    parameter int ITERATIONS = DEF_ITERATIONS,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_task                   i_task,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_cos,
    output logic signed [OUT_W-1:0] o_sin
);
    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam logic signed [WORD_WIDTH-1:0] C_INIT = ONE64[WORD_WIDTH-1:0];

    logic                         r_v   [ITERATIONS+1];
    logic                         r_neg [ITERATIONS+1];
    logic signed [WORD_WIDTH-1:0] r_c   [ITERATIONS+1];
    logic signed [WORD_WIDTH-1:0] r_s   [ITERATIONS+1];
    logic signed [WORD_WIDTH-1:0] r_t   [ITERATIONS+1];
    logic                         r_gv, r_gneg, r_ov;
    logic signed [33:0]           r_pc, r_ps;
    logic signed [OUT_W-1:0]      r_cos, r_sin;

    logic                         w_en;
    logic signed [63:0]           w_t64, w_c64, w_s64;
    logic signed [50:0]           w_pc, w_ps;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ov;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

    always_comb begin
        w_t64 = 64'(i_task.angle);
        w_c64 = 64'(r_c[ITERATIONS]);
        w_s64 = 64'(r_s[ITERATIONS]);
        w_pc  = 51'($signed(w_c64[33:0])) * 51'(GAIN_FX);
        w_ps  = 51'($signed(w_s64[33:0])) * 51'(GAIN_FX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c[0]   <= C_INIT;
            r_s[0]   <= '0;
            r_t[0]   <= w_t64[WORD_WIDTH-1:0];
            r_neg[0] <= i_task.negate;
        end
    end

    for (genvar j = 0; j < ITERATIONS; j++) begin : g_stage
        localparam logic [63:0] ATAN64 = 64'(atan_fx(j));
        localparam logic signed [WORD_WIDTH-1:0] ATAN_W = ATAN64[WORD_WIDTH-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_neg[j+1] <= r_neg[j];
                if (r_t[j] < 0) begin
                    r_c[j+1] <= r_c[j] + (r_s[j] >>> j);
                    r_s[j+1] <= r_s[j] - (r_c[j] >>> j);
                    r_t[j+1] <= r_t[j] + ATAN_W;
                end else begin
                    r_c[j+1] <= r_c[j] - (r_s[j] >>> j);
                    r_s[j+1] <= r_s[j] + (r_c[j] >>> j);
                    r_t[j+1] <= r_t[j] - ATAN_W;
                end
            end
        end
    end

    function automatic logic signed [OUT_W-1:0] finish(input logic signed [33:0] p,
                                                       input logic neg);
        logic signed [33:0]           sh;
        logic signed [63:0]           sh64;
        logic signed [WORD_WIDTH-1:0] w;
        logic signed [63:0]           w64;
        sh   = p >>> FRAC_BITS;
        sh64 = 64'(sh);
        w    = sh64[WORD_WIDTH-1:0];
        if (neg) begin
            w = -w;
        end
        w64 = 64'(w);
        return w64[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_gv <= r_v[ITERATIONS];
            r_ov <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc  <= w_pc[33:0];
            r_ps  <= w_ps[33:0];
            r_gneg <= r_neg[ITERATIONS];
            r_cos <= finish(r_pc, r_gneg);
            r_sin <= finish(r_ps, r_gneg);
        end
    end
endmodule

FILE: hdl/cordic_sine_cosine_unit.sv
// Top level of the CORDIC sine and cosine unit.
// Takes one signed angle in radians (32 bits, 16 fraction bits) per beat and returns its
// cosine and sine with 16 fraction bits in 18-bit fields. A new beat is accepted every
// cycle while the output side keeps up. A beat passes through the range reduction and
// folding registers, the queue, an entry stage and one stage per CORDIC iteration,
// a gain multiply stage and an output register. A four-entry queue between the front
// end and the rotation pipeline absorbs stalls.
`timescale 1ns / 1ps
module cordic_sine_cosine_unit import csc_pkg::*; #(
    parameter int ITERATIONS = DEF_ITERATIONS,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // angle_in[31:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // cos_out[17:0], sin_out[35:18], zero[39:36]
);
    logic                    w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    t_task                   w_fq_task, w_qb_task;
    logic signed [OUT_W-1:0] w_cos, w_sin;

    csc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_angle ($signed(i_s_axis_tdata)),
        .o_valid (w_fq_valid),
        .i_ready (w_fq_ready),
        .o_task  (w_fq_task)
    );

    csc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_task  (w_fq_task),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_task  (w_qb_task)
    );

    csc_back #(
        .ITERATIONS (ITERATIONS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qb_valid),
        .o_ready (w_qb_ready),
        .i_task  (w_qb_task),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign o_m_axis_tdata = {4'd0, w_sin, w_cos};
endmodule
